// ===== src/config_text_tokenizer_macros.svh =====
// Assertion macros for the configuration-text tokenizer.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef CONFIG_TEXT_TOKENIZER_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication: when ante holds, cons holds at that edge
`define CTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tokenizer check failed");
// next-cycle implication: when ante holds, cons holds at the following edge
`define CTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tokenizer check failed");
`else
`define CTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/cttok_pkg.sv =====
// Shared types, codes and character tables for the configuration-text tokenizer.
// No dependencies; used by the lexer, the result queue and the top level.
`default_nettype none

package cttok_pkg;

    // lexer mode
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_COMMENT = 4'd1,
        MODE_KW_AT   = 4'd2,
        MODE_KEYWORD = 4'd3,
        MODE_IDENT   = 4'd4,
        MODE_NUMBER  = 4'd5,
        MODE_SQ      = 4'd6,
        MODE_DQ      = 4'd7,
        MODE_DQ_ESC  = 4'd8,
        MODE_ERROR   = 4'd9
    } mode_t;

    // event codes
    localparam logic [1:0] EV_CHAR = 2'd0;
    localparam logic [1:0] EV_END  = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;

    // token types
    localparam logic [3:0] TOK_EOF      = 4'd0;
    localparam logic [3:0] TOK_INCLUDE  = 4'd1;
    localparam logic [3:0] TOK_IDENT    = 4'd2;
    localparam logic [3:0] TOK_NUMBER   = 4'd3;
    localparam logic [3:0] TOK_SQ_STR   = 4'd4;
    localparam logic [3:0] TOK_DQ_STR   = 4'd5;
    localparam logic [3:0] TOK_COMMA    = 4'd6;
    localparam logic [3:0] TOK_COLON    = 4'd7;
    localparam logic [3:0] TOK_SEMI     = 4'd8;
    localparam logic [3:0] TOK_LBRACE   = 4'd9;
    localparam logic [3:0] TOK_RBRACE   = 4'd10;
    localparam logic [3:0] TOK_LBRACKET = 4'd11;
    localparam logic [3:0] TOK_RBRACKET = 4'd12;

    // error codes
    localparam logic [2:0] ERR_EMPTY_KW   = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN_KW = 3'd1;
    localparam logic [2:0] ERR_DIGIT_ID   = 3'd2;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
    localparam logic [2:0] ERR_ILLEGAL    = 3'd4;

    // configuration register indexes
    localparam logic REG_ALLOW_LEAD_DIGIT = 1'b0;
    localparam logic REG_NUMBER_ENABLE    = 1'b1;

    // characters with a role of their own
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // length of the include keyword, '@' counted
    localparam logic [3:0] KW_LEN = 4'd8;

    // most results one item can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic       allow_digit_first;
        logic       number_enable;
    } cfg_t;

    // one result; packed so that event_res sits in the lowest bits
    typedef struct packed {
        logic       last;
        logic [2:0] err;
        logic [7:0] ch;
        logic [3:0] tok;
        logic [1:0] ev;
    } res_t;

    // the results of one step, oldest in item[0]
    typedef struct packed {
        logic [1:0]           cnt;
        res_t [MAX_RES-1:0]   item;
    } batch_t;

    typedef struct packed {
        mode_t      mode;
        logic       digit_first;
        logic       digits_only;
        logic [3:0] kw_pos;
        logic       kw_mis;
    } lex_state_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    // "@include", one character per position
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_AT;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6E;
            3'd3:    c = 8'h63;
            3'd4:    c = 8'h6C;
            3'd5:    c = 8'h75;
            3'd6:    c = 8'h64;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    // symbol token for a one-character symbol, TOK_EOF when c is none
    function automatic logic [3:0] sym_token(input logic [7:0] c);
        logic [3:0] t;
        case (c)
            8'h2C:   t = TOK_COMMA;
            8'h3A:   t = TOK_COLON;
            8'h3B:   t = TOK_SEMI;
            8'h7B:   t = TOK_LBRACE;
            8'h7D:   t = TOK_RBRACE;
            8'h5B:   t = TOK_LBRACKET;
            8'h5D:   t = TOK_RBRACKET;
            default: t = TOK_EOF;
        endcase
        return t;
    endfunction

    // append one result unless the batch is full
    function automatic batch_t push_res(input batch_t b, input logic [1:0] ev,
                                        input logic [3:0] tok, input logic [7:0] ch,
                                        input logic [2:0] err);
        batch_t r;
        r = b;
        if (b.cnt < 2'(MAX_RES)) begin
            r.item[b.cnt] = '{last: 1'b0, err: err, ch: ch, tok: tok, ev: ev};
            r.cnt         = b.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/cttok_lexer.sv =====
// Lexer state and the one-item step logic of the tokenizer.
// Depends on cttok_pkg for the state, result and batch types.
`default_nettype none

module cttok_lexer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire logic [7:0]          in_ch,
    input  wire logic                in_eoi,
    input  wire cttok_pkg::cfg_t     cfg,
    output cttok_pkg::batch_t        batch,
    output cttok_pkg::mode_t         lex_mode
);
    import cttok_pkg::*;

    lex_state_t state_reg;
    lex_state_t state_next;

    // one lexing step: close the open word if needed, then start a new token
    always_comb begin
        lex_state_t st;
        batch_t     b;
        logic       do_close;
        logic       close_ok;
        logic       do_start;
        logic [3:0] sym;

        st       = state_reg;
        b        = '0;
        do_close = 1'b0;
        close_ok = 1'b0;
        do_start = 1'b0;
        sym      = sym_token(in_ch);

        if (in_eoi) begin
            case (state_reg.mode) inside
                MODE_ERROR: begin
                    st.mode = MODE_IDLE;
                end
                MODE_KW_AT: begin
                    b = push_res(b, EV_ERR, TOK_EOF, 8'd0, ERR_EMPTY_KW);
                end
                MODE_SQ, MODE_DQ, MODE_DQ_ESC: begin
                    b = push_res(b, EV_ERR, TOK_EOF, 8'd0, ERR_UNCLOSED);
                end
                MODE_IDENT, MODE_NUMBER, MODE_KEYWORD: begin
                    do_close = 1'b1;
                end
                default: begin
                    b = push_res(b, EV_END, TOK_EOF, 8'd0, ERR_EMPTY_KW);
                end
            endcase
        end else begin
            case (state_reg.mode) inside
                MODE_ERROR: begin
                    st.mode = MODE_ERROR;
                end
                MODE_COMMENT: begin
                    if (in_ch == CH_LF) begin
                        st.mode = MODE_IDLE;
                    end
                end
                MODE_KW_AT, MODE_KEYWORD: begin
                    if (is_alpha(in_ch)) begin
                        b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                        if (!st.kw_mis && st.kw_pos < KW_LEN &&
                            kw_char(st.kw_pos[2:0]) == in_ch) begin
                            st.kw_pos = st.kw_pos + 4'd1;
                        end else begin
                            st.kw_mis = 1'b1;
                        end
                        st.mode = MODE_KEYWORD;
                    end else if (state_reg.mode == MODE_KW_AT) begin
                        b       = push_res(b, EV_ERR, TOK_EOF, 8'd0, ERR_EMPTY_KW);
                        st.mode = MODE_ERROR;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (in_ch == CH_UNDERSCORE || in_ch == CH_MINUS || in_ch == CH_STAR ||
                        in_ch == CH_SLASH || is_alpha(in_ch)) begin
                        st.digits_only = 1'b0;
                        b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    end else if (is_digit(in_ch)) begin
                        b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    end else begin
                        do_close = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_ch)) begin
                        b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    end else begin
                        do_close = 1'b1;
                    end
                end
                MODE_SQ: begin
                    if (in_ch == CH_SQUOTE) begin
                        b       = push_res(b, EV_END, TOK_SQ_STR, 8'd0, ERR_EMPTY_KW);
                        st.mode = MODE_IDLE;
                    end else begin
                        b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    end
                end
                MODE_DQ: begin
                    if (in_ch == CH_BACKSLASH) begin
                        st.mode = MODE_DQ_ESC;
                    end else if (in_ch == CH_DQUOTE) begin
                        b       = push_res(b, EV_END, TOK_DQ_STR, 8'd0, ERR_EMPTY_KW);
                        st.mode = MODE_IDLE;
                    end else begin
                        b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    end
                end
                MODE_DQ_ESC: begin
                    b       = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    st.mode = MODE_DQ;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
        end

        // close an ident, number or keyword token
        if (do_close) begin
            case (state_reg.mode)
                MODE_IDENT: begin
                    if (st.digit_first && st.digits_only) begin
                        b       = push_res(b, EV_ERR, TOK_EOF, 8'd0, ERR_DIGIT_ID);
                        st.mode = MODE_ERROR;
                    end else begin
                        b        = push_res(b, EV_END, TOK_IDENT, 8'd0, ERR_EMPTY_KW);
                        close_ok = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    b        = push_res(b, EV_END, TOK_NUMBER, 8'd0, ERR_EMPTY_KW);
                    close_ok = 1'b1;
                end
                default: begin
                    if (st.kw_mis || st.kw_pos != KW_LEN) begin
                        b       = push_res(b, EV_ERR, TOK_EOF, 8'd0, ERR_UNKNOWN_KW);
                        st.mode = MODE_ERROR;
                    end else begin
                        b        = push_res(b, EV_END, TOK_INCLUDE, 8'd0, ERR_EMPTY_KW);
                        close_ok = 1'b1;
                    end
                end
            endcase
            if (close_ok) begin
                st.mode = MODE_IDLE;
                if (in_eoi) begin
                    b = push_res(b, EV_END, TOK_EOF, 8'd0, ERR_EMPTY_KW);
                end else begin
                    do_start = 1'b1;
                end
            end
        end

        // treat the byte as the first of a new token
        if (do_start) begin
            st.mode = MODE_IDLE;
            if (!is_space(in_ch)) begin
                if (in_ch == CH_HASH) begin
                    st.mode = MODE_COMMENT;
                end else if (in_ch == CH_AT) begin
                    b         = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    st.kw_pos = 4'd1;
                    st.kw_mis = 1'b0;
                    st.mode   = MODE_KW_AT;
                end else if (in_ch == CH_UNDERSCORE || is_alpha(in_ch) ||
                             (!cfg.number_enable && cfg.allow_digit_first &&
                              is_digit(in_ch))) begin
                    b              = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    st.digit_first = is_digit(in_ch);
                    st.digits_only = 1'b1;
                    st.mode        = MODE_IDENT;
                end else if (cfg.number_enable && is_digit(in_ch)) begin
                    b       = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    st.mode = MODE_NUMBER;
                end else if (in_ch == CH_SQUOTE) begin
                    st.mode = MODE_SQ;
                end else if (in_ch == CH_DQUOTE) begin
                    st.mode = MODE_DQ;
                end else if (sym != TOK_EOF) begin
                    b = push_res(b, EV_CHAR, TOK_EOF, in_ch, ERR_EMPTY_KW);
                    b = push_res(b, EV_END, sym, 8'd0, ERR_EMPTY_KW);
                end else begin
                    b       = push_res(b, EV_ERR, TOK_EOF, 8'd0, ERR_ILLEGAL);
                    st.mode = MODE_ERROR;
                end
            end
        end

        // end of input always leaves a clean idle state
        if (in_eoi) begin
            st.mode        = MODE_IDLE;
            st.digit_first = 1'b0;
            st.digits_only = 1'b1;
            st.kw_pos      = 4'd0;
            st.kw_mis      = 1'b0;
        end

        // flag the final result of the step
        if (b.cnt != 2'd0) begin
            b.item[b.cnt - 2'd1].last = 1'b1;
        end

        state_next = st;
        batch      = b;
    end

    // advance the state on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= MODE_IDLE;
            state_reg.digit_first <= 1'b0;
            state_reg.digits_only <= 1'b1;
            state_reg.kw_pos      <= 4'd0;
            state_reg.kw_mis      <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    assign lex_mode = state_reg.mode;

endmodule

`default_nettype wire

// ===== src/cttok_result_fifo.sv =====
// Result queue of the tokenizer: takes up to three results a cycle, gives at most one.
// Depends on cttok_pkg for the result and batch types.
`default_nettype none

module cttok_result_fifo #(
    parameter int DEPTH = 8     // power of two, at least 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push_en,
    input  wire cttok_pkg::batch_t   push_batch,
    output logic                     room,
    output logic                     head_valid,
    output cttok_pkg::res_t          head,
    input  wire logic                pop_en
);
    import cttok_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] push_n;
    logic [CNT_W-1:0] count_next;

    assign push_n     = push_en ? CNT_W'(push_batch.cnt) : '0;
    assign count_next = count_reg + push_n - (pop_en ? CNT_W'(1) : '0);

    // room for a full batch, counted without this cycle's pop
    assign room       = (count_reg <= CNT_W'(DEPTH - MAX_RES));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    // write the batch in order behind the tail
    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (push_en && 2'(k) < push_batch.cnt) begin
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_batch.item[k];
            end
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n[PTR_W-1:0];
            if (pop_en) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/config_text_tokenizer.sv =====
// Configuration-text tokenizer, top level. An item held in the input register is lexed
// and its results are written into the result queue, which offers them at its head.
// Throughput: one item per cycle while the queue has room for a full batch; the result
// port moves one result per cycle while m_tready is high, and the queue absorbs bursts.
// Reset (aresetn low, synchronous): lexer idle, queue empty, both registers zero.
// Depends on cttok_pkg, cttok_lexer, cttok_result_fifo and the assertion macros.
`default_nettype none
`include "config_text_tokenizer_macros.svh"

module config_text_tokenizer #(
    parameter int FIFO_DEPTH = 8    // result queue entries, power of two, at least 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // end_of_input
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] event_res, [5:2] token_type,
                                        // [13:6] char_out, [16:14] error_code
    output logic             m_tlast,   // last
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic        cfg_data
);
    import cttok_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_eoi_reg;
    logic       allow_lead_reg;
    logic       number_en_reg;
    cfg_t       cfg;
    batch_t     batch;
    mode_t      lex_mode;
    logic       fifo_room;
    logic       fire;
    res_t       head;

    // step when an item waits and the queue can take a full batch
    assign fire      = in_valid_reg && fifo_room;
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign cfg       = '{allow_digit_first: allow_lead_reg, number_enable: number_en_reg};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_eoi_reg <= s_tlast;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_lead_reg <= 1'b0;
            number_en_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ALLOW_LEAD_DIGIT: allow_lead_reg <= cfg_data;
                REG_NUMBER_ENABLE:    number_en_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    cttok_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (fire),
        .in_ch    (in_ch_reg),
        .in_eoi   (in_eoi_reg),
        .cfg      (cfg),
        .batch    (batch),
        .lex_mode (lex_mode)
    );

    cttok_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (fire),
        .push_batch (batch),
        .room       (fifo_room),
        .head_valid (m_tvalid),
        .head       (head),
        .pop_en     (m_tvalid && m_tready)
    );

    // pack the result
    assign m_tdata = {7'd0, head.err, head.ch, head.tok, head.ev};
    assign m_tlast = head.last;

    // end of input always returns the lexer to idle
    `CTT_ASSERT_NXT(a_eoi_idle, aclk, aresetn, fire && in_eoi_reg, lex_mode == MODE_IDLE)
    // after an error, bytes give no result
    `CTT_ASSERT_IMP(a_err_quiet, aclk, aresetn,
        fire && !in_eoi_reg && lex_mode == MODE_ERROR, batch.cnt == 2'd0)
    // an item held back by a full queue stays in the input register
    `CTT_ASSERT_NXT(a_hold_item, aclk, aresetn, in_valid_reg && !fire,
        in_valid_reg && $stable(in_ch_reg) && $stable(in_eoi_reg))

endmodule

`default_nettype wire
